// ===== design/w30p_pkg.sv =====
// Shared constants, types and helper functions of the mod-30 wheel presieve.
`timescale 1ns / 1ps

package w30p_pkg;

   // Default data word width of the sieve bitmap stream.
   localparam int WORD_BITS_DEFAULT = 64;

   // Numbers covered by one wheel byte.
   localparam int WHEEL_SPAN = 30;

   // Small primes 7..61 handled by the block.
   localparam int NUM_SMALL = 15;

   // Width of one running residue (every prime is below 64).
   localparam int OFF_BITS = 6;

   // Width of the block start register.
   localparam int BS_BITS = 48;

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_START   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOWEST_PRIME  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HIGHEST_PRIME = 2'd2;

   // Reset values of the prime range registers.
   localparam logic [OFF_BITS-1:0] LOWEST_RESET  = 6'd7;
   localparam logic [OFF_BITS-1:0] HIGHEST_RESET = 6'd61;

   // One residue per small prime, in increasing prime order.
   typedef logic [NUM_SMALL-1:0][OFF_BITS-1:0] offset_vec_type;

   // Small prime at a given list position.
   function automatic int prime_of(input int idx);
      int p;
      unique case (idx)
         0:       p = 7;
         1:       p = 11;
         2:       p = 13;
         3:       p = 17;
         4:       p = 19;
         5:       p = 23;
         6:       p = 29;
         7:       p = 31;
         8:       p = 37;
         9:       p = 41;
         10:      p = 43;
         11:      p = 47;
         12:      p = 53;
         13:      p = 59;
         14:      p = 61;
         default: p = 7;
      endcase
      return p;
   endfunction

   // Wheel residue that bit b of a wheel byte stands for.
   function automatic int wheel_res(input int b);
      int r;
      unique case (b)
         0:       r = 1;
         1:       r = 7;
         2:       r = 11;
         3:       r = 13;
         4:       r = 17;
         5:       r = 19;
         6:       r = 23;
         7:       r = 29;
         default: r = 1;
      endcase
      return r;
   endfunction

   // Remainder by repeated subtraction; used only on constants at elaboration.
   function automatic int const_mod(input int v, input int m);
      int r;
      r = v;
      for (int k = 0; k < 64; k++) begin
         if (r >= m) begin
            r = r - m;
         end
      end
      return r;
   endfunction

endpackage

// ===== design/w30p_residue.sv =====
// Start residue unit: block_start modulo each small prime, by nibble tables in two steps.
`timescale 1ns / 1ps

module w30p_residue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [w30p_pkg::BS_BITS-1:0]  start_value,
   output logic                          busy,
   output w30p_pkg::offset_vec_type      start_res
);
   import w30p_pkg::*;

   localparam int NIBBLES  = BS_BITS / 4;
   localparam int SUM_BITS = 10;

   typedef logic [15:0][OFF_BITS-1:0]          nib_table_type;
   typedef logic [NUM_SMALL-1:0][SUM_BITS-1:0] sum_vec_type;

   // Residues of v * 16^k modulo p for every nibble value v.
   function automatic nib_table_type nib_table(input int k, input int p);
      nib_table_type tbl;
      int            w;
      int            acc;
      w = 1;
      for (int s = 0; s < 4 * k; s++) begin
         w = 2 * w;
         if (w >= p) begin
            w = w - p;
         end
      end
      acc = 0;
      for (int v = 0; v < 16; v++) begin
         tbl[v] = OFF_BITS'(acc);
         acc = acc + w;
         if (acc >= p) begin
            acc = acc - p;
         end
      end
      return tbl;
   endfunction

   sum_vec_type    sum_ff;
   sum_vec_type    sum_in;
   offset_vec_type res_ff;
   offset_vec_type res_in;
   logic           pend_ff;

   assign busy      = pend_ff;
   assign start_res = res_ff;

   for (genvar i = 0; i < NUM_SMALL; i++) begin : g_prime
      localparam logic [SUM_BITS-1:0] P1 = SUM_BITS'(prime_of(i));
      localparam logic [SUM_BITS-1:0] P2 = SUM_BITS'(2 * prime_of(i));
      localparam logic [SUM_BITS-1:0] P4 = SUM_BITS'(4 * prime_of(i));
      localparam logic [SUM_BITS-1:0] P8 = SUM_BITS'(8 * prime_of(i));

      logic [NIBBLES-1:0][OFF_BITS-1:0] term;

      // Each nibble contributes its value times its weight, already reduced.
      for (genvar k = 0; k < NIBBLES; k++) begin : g_nib
         localparam nib_table_type TBL = nib_table(k, prime_of(i));
         assign term[k] = TBL[start_value[4*k +: 4]];
      end

      // Adder tree over the twelve reduced nibble terms.
      always_comb begin
         logic [5:0][SUM_BITS-1:0] pair;
         logic [2:0][SUM_BITS-1:0] quad;
         for (int m = 0; m < 6; m++) begin
            pair[m] = SUM_BITS'(term[2*m]) + SUM_BITS'(term[2*m+1]);
         end
         for (int n = 0; n < 3; n++) begin
            quad[n] = pair[2*n] + pair[2*n+1];
         end
         sum_in[i] = quad[0] + quad[1] + quad[2];
      end

      // The sum stays below 16 p, so four conditional subtracts finish the reduction.
      always_comb begin
         logic [SUM_BITS-1:0] v;
         v = sum_ff[i];
         if (v >= P8) begin
            v = v - P8;
         end
         if (v >= P4) begin
            v = v - P4;
         end
         if (v >= P2) begin
            v = v - P2;
         end
         if (v >= P1) begin
            v = v - P1;
         end
         res_in[i] = v[OFF_BITS-1:0];
      end
   end

   // A new block start is summed in the write cycle and reduced in the next one.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         sum_ff  <= '0;
         res_ff  <= '0;
      end else begin
         pend_ff <= load;
         if (load) begin
            sum_ff <= sum_in;
         end
         if (pend_ff) begin
            res_ff <= res_in;
         end
      end
   end

endmodule

// ===== design/w30p_marks.sv =====
// Mark generator: builds the multiples mask of the enabled primes for one word.
`timescale 1ns / 1ps

module w30p_marks #(
   parameter int WORD_BITS = w30p_pkg::WORD_BITS_DEFAULT
) (
   input  w30p_pkg::offset_vec_type        offsets,
   input  logic [WORD_BITS-1:0]            word_in,
   input  logic [w30p_pkg::OFF_BITS-1:0]   lowest_prime,
   input  logic [w30p_pkg::OFF_BITS-1:0]   highest_prime,
   output logic [WORD_BITS-1:0]            word_out
);
   import w30p_pkg::*;

   logic [NUM_SMALL-1:0] enable;
   logic [NUM_SMALL-1:0] hit [WORD_BITS];
   logic [WORD_BITS-1:0] marks;
   logic                 replace;

   // Enables: single primes by range, the others only as whole groups.
   always_comb begin
      logic grp_a;
      logic grp_b;
      logic grp_c;
      grp_a = (lowest_prime <= 6'd17) && (highest_prime >= 6'd31);
      grp_b = (lowest_prime <= 6'd41) && (highest_prime >= 6'd47);
      grp_c = (lowest_prime <= 6'd59) && (highest_prime >= 6'd61);
      for (int i = 0; i < NUM_SMALL; i++) begin
         if (prime_of(i) >= 17 && prime_of(i) <= 31) begin
            enable[i] = grp_a;
         end else if (prime_of(i) >= 41 && prime_of(i) <= 47) begin
            enable[i] = grp_b;
         end else if (prime_of(i) >= 59) begin
            enable[i] = grp_c;
         end else begin
            enable[i] = (lowest_prime <= OFF_BITS'(prime_of(i)))
                     && (highest_prime >= OFF_BITS'(prime_of(i)));
         end
      end
   end

   // A bit is a multiple of p exactly when the word residue hits one constant value.
   for (genvar k = 0; k < WORD_BITS; k++) begin : g_bit
      for (genvar i = 0; i < NUM_SMALL; i++) begin : g_prime
         localparam int P   = prime_of(i);
         localparam int POS = const_mod(WHEEL_SPAN * (k / 8) + wheel_res(k % 8), P);
         localparam logic [OFF_BITS-1:0] HIT_RES = OFF_BITS'(const_mod(P - POS, P));
         assign hit[k][i] = enable[i] && (offsets[i] == HIT_RES);
      end
      assign marks[k] = |hit[k];
   end

   // With 7 enabled the marks replace the word, otherwise they are ORed in.
   assign replace  = (lowest_prime <= 6'd7) && (highest_prime >= 6'd7);
   assign word_out = replace ? marks : (word_in | marks);

endmodule

// ===== design/wheel30_small_prime_presieve.sv =====
// Top level of the mod-30 wheel small-prime presieve stream block.
//
//   channel | direction | beat contents
//   --------+-----------+---------------------------------------------------
//   req_    | in        | tdata: block_word; tuser: first_word
//   rsp_    | out       | tdata: sieved_word
//   csr_    | in        | index: register number; data: register value
//
// One word is taken every cycle unless rsp_ stalls or the residue unit is busy.
// A write of block_start starts the residue unit, which sums nibble terms and
// reduces them modulo every prime; req_tready stays low while the unit is busy.
// Reset zeroes the running and start residues and sets the prime range to 7..61.
// A stalled result holds a full stage one; new words then wait until stage one moves.
`timescale 1ns / 1ps

module wheel30_small_prime_presieve #(
   parameter int WORD_BITS = w30p_pkg::WORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [WORD_BITS-1:0]              req_tdata,   // block_word
   input  logic                              req_tuser,   // first_word
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [WORD_BITS-1:0]              rsp_tdata,   // sieved_word
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [w30p_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [w30p_pkg::BS_BITS-1:0]      csr_data
);
   import w30p_pkg::*;

   localparam int BYTES_PER_WORD = WORD_BITS / 8;

   logic                 csr_write;
   logic                 res_busy;
   offset_vec_type       start_res;
   offset_vec_type       eff_off;
   offset_vec_type       off_ff;
   offset_vec_type       off_in;
   logic [OFF_BITS-1:0]  lowest_prime_ff;
   logic [OFF_BITS-1:0]  highest_prime_ff;
   logic                 s1_valid_ff;
   logic [WORD_BITS-1:0] s1_word_ff;
   offset_vec_type       s1_off_ff;
   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] rsp_data_ff;
   logic [WORD_BITS-1:0] sieved;
   logic                 out_free;
   logic                 s1_move;
   logic                 req_take;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Prime range registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_prime_ff  <= LOWEST_RESET;
         highest_prime_ff <= HIGHEST_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_LOWEST_PRIME) begin
            lowest_prime_ff <= csr_data[OFF_BITS-1:0];
         end
         if (csr_index == CSR_HIGHEST_PRIME) begin
            highest_prime_ff <= csr_data[OFF_BITS-1:0];
         end
      end
   end

   // Block start residues, computed after each block_start write.
   w30p_residue u_residue (
      .clock       (clock),
      .reset       (reset),
      .load        (csr_write && (csr_index == CSR_BLOCK_START)),
      .start_value (csr_data),
      .busy        (res_busy),
      .start_res   (start_res)
   );

   // Pipeline handshake: each stage moves when the one after it has room.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = (!s1_valid_ff || out_free) && !res_busy;
   assign req_take   = req_tvalid && req_tready;

   // Residues for this word and the advance by one word span modulo each prime.
   for (genvar i = 0; i < NUM_SMALL; i++) begin : g_adv
      localparam logic [OFF_BITS:0] ADV =
         (OFF_BITS + 1)'(const_mod(WHEEL_SPAN * BYTES_PER_WORD, prime_of(i)));
      localparam logic [OFF_BITS:0] P = (OFF_BITS + 1)'(prime_of(i));

      always_comb begin
         logic [OFF_BITS:0] sum;
         eff_off[i] = req_tuser ? start_res[i] : off_ff[i];
         sum        = {1'b0, eff_off[i]} + ADV;
         if (sum >= P) begin
            sum = sum - P;
         end
         off_in[i] = sum[OFF_BITS-1:0];
      end
   end

   // Stage one: captured word, its residues, and the running residues.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         off_ff      <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
            off_ff      <= off_in;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_tdata;
         s1_off_ff  <= eff_off;
      end
   end

   w30p_marks #(
      .WORD_BITS (WORD_BITS)
   ) u_marks (
      .offsets       (s1_off_ff),
      .word_in       (s1_word_ff),
      .lowest_prime  (lowest_prime_ff),
      .highest_prime (highest_prime_ff),
      .word_out      (sieved)
   );

   // Stage two: result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= sieved;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Running residues always stay below their prime.
   for (genvar i = 0; i < NUM_SMALL; i++) begin : g_chk
      a_off_range: assert property (@(posedge clock) disable iff (reset)
         off_ff[i] < OFF_BITS'(prime_of(i)))
         else $error("running residue out of range");
   end

   // The residue unit only starts on a block_start write.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(res_busy) |-> $past(csr_write && (csr_index == CSR_BLOCK_START)))
      else $error("residue unit started without a block_start write");

   // A blocked stage-one word keeps its payload.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_word_ff)
                                      && $stable(s1_off_ff)))
      else $error("stage one changed while blocked");

   // A word leaving stage one shows up as a result.
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("stage one word lost");

endmodule
